FILE: rtl/modexp_pkg.sv
package modexp_pkg;

   // Width of the signed base and exponent; the modulus and result are one bit narrower
   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] base;
      logic signed [DATA_WIDTH-1:0] exponent;
      logic [DATA_WIDTH-2:0]        modulus;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-2:0] power;
      logic                  bad_modulus;
   } rsp_type;

endpackage

FILE: rtl/modular_exponentiation.sv
// Sequence: reduce the base modulo the modulus, then per exponent bit a check and a modular
// product each for the multiply (when the bit is set) and the square (always), then finish.
// A zero modulus skips the reduction and the products and goes straight to the finish.
// Throughput: one word at a time, set by the bit-serial shift-and-add modular multiplier.
// A finished word waits in the output register while the next word is taken in.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module modular_exponentiation (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  modexp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output modexp_pkg::rsp_type rsp_data
);

   localparam int W     = modexp_pkg::DATA_WIDTH;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] LAST_RED = CNT_W'(W - 1);
   localparam logic [CNT_W-1:0] LAST_MUL = CNT_W'(W - 2);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_REDUCE = 7'b0000010,
      ST_FIXUP  = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_SQR    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   // (a + b) mod m for a, b below m
   function automatic logic [W-2:0] add_mod(input logic [W-2:0] a,
                                            input logic [W-2:0] b,
                                            input logic [W-2:0] m);
      logic [W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[W-2:0];
   endfunction

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   modexp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [W-1:0]       mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [W-2:0]       mod_ff, mod_in;
   logic [W-1:0]       exp_ff, exp_in;
   logic [W-2:0]       res_ff, res_in;
   logic [W-2:0]       base_ff, base_in;
   logic               bad_ff, bad_in;
   logic [W-2:0]       acc_ff, acc_in;
   logic [W-2:0]       dbl_ff, dbl_in;
   logic [W-2:0]       mlt_ff, mlt_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [W-1:0]       red_sum;
   logic [W-2:0]       red_nx;
   logic [W-2:0]       acc_nx;
   logic [W-2:0]       dbl_nx;
   logic               req_take;
   logic               out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One restoring step of the base reduction: shift in the next magnitude bit
   always_comb begin
      red_sum = {acc_ff, mag_ff[W-1]};
      if (red_sum >= {1'b0, mod_ff}) red_sum = red_sum - {1'b0, mod_ff};
      red_nx = red_sum[W-2:0];
   end

   // One step of the shift-and-add product: add on a set multiplier bit, double the operand
   assign acc_nx = mlt_ff[0] ? add_mod(acc_ff, dbl_ff, mod_ff) : acc_ff;
   assign dbl_nx = add_mod(dbl_ff, dbl_ff, mod_ff);

   // Sequence the reduction, the exponent bits and the one or two products per bit
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mod_in       = mod_ff;
      exp_in       = exp_ff;
      res_in       = res_ff;
      base_in      = base_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      dbl_in       = dbl_ff;
      mlt_in       = mlt_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in = req_data.base[W-1];
               mag_in = req_data.base[W-1] ? (~req_data.base + W'(1)) : req_data.base;
               exp_in = req_data.exponent;
               mod_in = req_data.modulus;
               acc_in = '0;
               cnt_in = '0;
               if (req_data.modulus == '0) begin
                  bad_in   = 1'b1;
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  bad_in   = 1'b0;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            acc_in = red_nx;
            mag_in = {mag_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_RED) state_in = ST_FIXUP;
         end
         ST_FIXUP: begin
            // Lift a negative remainder into range
            base_in = (neg_ff && acc_ff != '0) ? (mod_ff - acc_ff) : acc_ff;
            res_in  = (mod_ff == (W-1)'(1)) ? '0 : (W-1)'(1);
            state_in = exp_ff[W-1] ? ST_DONE : ST_CHECK;
         end
         ST_CHECK: begin
            acc_in = '0;
            cnt_in = '0;
            mlt_in = base_ff;
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               dbl_in   = res_ff;
               state_in = ST_MUL;
            end else begin
               dbl_in   = base_ff;
               state_in = ST_SQR;
            end
         end
         ST_MUL: begin
            acc_in = acc_nx;
            dbl_in = dbl_nx;
            mlt_in = mlt_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_MUL) begin
               res_in   = acc_nx;
               acc_in   = '0;
               dbl_in   = base_ff;
               mlt_in   = base_ff;
               cnt_in   = '0;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            acc_in = acc_nx;
            dbl_in = dbl_nx;
            mlt_in = mlt_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_MUL) begin
               base_in  = acc_nx;
               exp_in   = exp_ff >> 1;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.power       = res_ff;
               rsp_data_in.bad_modulus = bad_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      mod_ff      <= mod_in;
      exp_ff      <= exp_in;
      res_ff      <= res_in;
      base_ff     <= base_in;
      bad_ff      <= bad_in;
      acc_ff      <= acc_in;
      dbl_ff      <= dbl_in;
      mlt_ff      <= mlt_in;
      cnt_ff      <= cnt_in;
   end

endmodule
